FILE: hw/rtl/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared codes, constants and types of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

    // Command codes carried in the operation field
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_NACK = 3'd5;

    localparam int          TICK_W             = 10;
    localparam logic [9:0]  RESET_PHASE_TICKS  = 10'd50;
    localparam logic [3:0]  LAST_DATA_BIT      = 4'd7;
    localparam logic [3:0]  ACK_SLOT_BIT       = 4'd8;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified tick, as it travels from the front to the back
    typedef struct packed {
        logic       launch;   // a command that may start when the engine is idle
        logic [2:0] op;
        logic [7:0] tx;
        logic       sda;
    } tick_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: hw/rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bit engine: one tick beat in, one bus/status beat out.
// A tick beat passes through the tick queue and then the back end's registers before its result goes valid.
// Throughput: one tick per cycle, set by the back end, which stalls while the result beat is not taken.
// Reset: engine idle, SCL and SDA released, phase_ticks back to 50.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] operation,
    input  logic [7:0] tx_byte,
    input  logic       sda_in,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [9:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_out,
    output logic       sda_release,
    output logic       busy_res,
    output logic       done_res,
    output logic       nack_seen,
    output logic [7:0] rx_byte
);

    i2cbe_pkg::queue_status_t q_status;
    i2cbe_pkg::tick_entry_t   push_entry;
    i2cbe_pkg::tick_entry_t   pop_entry;
    logic                     push;
    logic                     pop;

    i2cbe_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .tx_byte    (tx_byte),
        .sda_in     (sda_in),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    i2cbe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    i2cbe_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (!q_status.empty),
        .q_entry     (pop_entry),
        .pop         (pop),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_out     (scl_out),
        .sda_release (sda_release),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .nack_seen   (nack_seen),
        .rx_byte     (rx_byte)
    );

    // A finishing tick leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done beat while engine still busy");

    // A queued tick with room at the output becomes a result beat next cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.empty && (!out_valid || out_ready) |=> out_valid)
        else $error("queued tick not carried to the output");

    // Only the start command finishes with SDA held low, and it ends with SCL low
    a_finish_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && !sda_release |-> !scl_out)
        else $error("command finished with SDA low and SCL high");

endmodule

FILE: hw/rtl/i2cbe_front.sv
// ----------------------------------------------------------------------------
// i2cbe_front
// Input side: accepts tick beats and classifies the operation code.
// ----------------------------------------------------------------------------
module i2cbe_front
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            operation,
    input  logic [7:0]            tx_byte,
    input  logic                  sda_in,
    input  i2cbe_pkg::queue_status_t q_status,
    output logic                  push,
    output i2cbe_pkg::tick_entry_t push_entry
);

    logic launch;

    always_comb
    begin
        unique case (operation) inside
            i2cbe_pkg::OP_START, i2cbe_pkg::OP_STOP, i2cbe_pkg::OP_WRITE,
            i2cbe_pkg::OP_READ_ACK, i2cbe_pkg::OP_READ_NACK:
                launch = 1'b1;
            default:
                launch = 1'b0;
        endcase
    end

    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    // Unknown codes still take a tick slot, they just never launch
    assign push_entry.launch = launch;
    assign push_entry.op     = operation;
    assign push_entry.tx     = (operation == i2cbe_pkg::OP_WRITE) ? tx_byte : 8'd0;
    assign push_entry.sda    = sda_in;

endmodule

FILE: hw/rtl/i2cbe_queue.sv
// ----------------------------------------------------------------------------
// i2cbe_queue
// Short FIFO of classified ticks between the front and the back.
// ----------------------------------------------------------------------------
module i2cbe_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  i2cbe_pkg::tick_entry_t    push_entry,
    input  logic                      pop,
    output i2cbe_pkg::tick_entry_t    pop_entry,
    output i2cbe_pkg::queue_status_t  status
);

    i2cbe_pkg::tick_entry_t entry_reg [i2cbe_pkg::QUEUE_DEPTH];

    logic [i2cbe_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [i2cbe_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [i2cbe_pkg::QCNT_W-1:0] count_reg,  count_next;

    localparam logic [i2cbe_pkg::QPTR_W-1:0] PTR_LAST =
        i2cbe_pkg::QPTR_W'(i2cbe_pkg::QUEUE_DEPTH - 1);
    localparam logic [i2cbe_pkg::QCNT_W-1:0] CNT_FULL =
        i2cbe_pkg::QCNT_W'(i2cbe_pkg::QUEUE_DEPTH);

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign pop_entry    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/i2cbe_back.sv
// ----------------------------------------------------------------------------
// i2cbe_back
// Bit engine: runs one tick per queue entry and holds the result beat.
// ----------------------------------------------------------------------------
module i2cbe_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  i2cbe_pkg::tick_entry_t q_entry,
    output logic                   pop,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [9:0]             cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   scl_out,
    output logic                   sda_release,
    output logic                   busy_res,
    output logic                   done_res,
    output logic                   nack_seen,
    output logic [7:0]             rx_byte
);

    logic [2:0] cmd_reg,   cmd_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] bit_reg,   bit_next;
    logic [9:0] tick_reg,  tick_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg,   scl_next;
    logic       sda_reg,   sda_next;
    logic       ack_reg,   ack_next;
    logic [7:0] rx_reg,    rx_next;
    logic       done_reg,  done_next;
    logic       out_valid_reg;
    logic [9:0] phase_ticks_reg;

    logic       advance;
    logic       launch;
    logic [2:0] cmd;
    logic [1:0] ph;
    logic [3:0] bitn;
    logic [9:0] tc;
    logic [7:0] sb;
    logic       scl_lv;
    logic       sda_lv;
    logic       sample;
    logic [9:0] limit;
    logic       tick_last;
    logic       is_read;
    logic [1:0] ph_count;
    logic [3:0] last_bit;
    logic [7:0] shift_in;

    assign cfg_ready = 1'b1;
    assign advance   = q_valid && (!out_valid_reg || out_ready);
    assign pop       = advance;

    assign launch = (cmd_reg == i2cbe_pkg::OP_NONE) && q_entry.launch;
    assign cmd    = launch ? q_entry.op : cmd_reg;
    assign ph     = launch ? 2'd0 : phase_reg;
    assign bitn   = launch ? 4'd0 : bit_reg;
    assign tc     = launch ? 10'd0 : tick_reg;
    assign sb     = launch ? q_entry.tx : shift_reg;

    assign is_read  = (cmd == i2cbe_pkg::OP_READ_ACK) || (cmd == i2cbe_pkg::OP_READ_NACK);
    assign ph_count = (is_read && bitn < i2cbe_pkg::ACK_SLOT_BIT) ? 2'd2 : 2'd3;
    assign last_bit = (cmd == i2cbe_pkg::OP_START || cmd == i2cbe_pkg::OP_STOP)
                      ? 4'd0 : i2cbe_pkg::ACK_SLOT_BIT;
    assign limit     = (phase_ticks_reg == 10'd0) ? 10'd1 : phase_ticks_reg;
    assign tick_last = ({1'b0, tc} + 11'd1) >= {1'b0, limit};
    assign shift_in  = {sb[6:0], q_entry.sda};

    // Bus levels of the current phase
    always_comb
    begin
        scl_lv = 1'b1;
        sda_lv = 1'b1;
        sample = 1'b0;
        unique case (cmd)
            i2cbe_pkg::OP_START:
            begin
                scl_lv = (ph < 2'd2);
                sda_lv = (ph == 2'd0);
            end
            i2cbe_pkg::OP_STOP:
            begin
                scl_lv = (ph >= 2'd1);
                sda_lv = (ph == 2'd2);
            end
            i2cbe_pkg::OP_WRITE:
            begin
                scl_lv = (ph == 2'd1);
                if (bitn < i2cbe_pkg::ACK_SLOT_BIT)
                begin
                    // release SDA on the trailing phase of the last data bit
                    sda_lv = (ph == 2'd2 && bitn == i2cbe_pkg::LAST_DATA_BIT) ? 1'b1 : sb[7];
                end
                else
                begin
                    sample = (ph == 2'd1);
                end
            end
            default:
            begin
                if (bitn < i2cbe_pkg::ACK_SLOT_BIT)
                begin
                    scl_lv = (ph == 2'd0);
                    sample = (ph == 2'd0);
                end
                else
                begin
                    scl_lv = (ph == 2'd1);
                    sda_lv = (cmd == i2cbe_pkg::OP_READ_NACK);
                end
            end
        endcase
    end

    always_comb
    begin
        cmd_next   = cmd;
        phase_next = ph;
        bit_next   = bitn;
        tick_next  = tc;
        shift_next = sb;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        if (cmd != i2cbe_pkg::OP_NONE)
        begin
            scl_next = scl_lv;
            sda_next = sda_lv;
            if (tick_last)
            begin
                tick_next = 10'd0;
                if (sample)
                begin
                    if (cmd == i2cbe_pkg::OP_WRITE)
                    begin
                        ack_next = q_entry.sda;
                    end
                    else
                    begin
                        shift_next = shift_in;
                        if (bitn == i2cbe_pkg::LAST_DATA_BIT)
                        begin
                            rx_next = shift_in;
                        end
                    end
                end
                if (cmd == i2cbe_pkg::OP_WRITE && bitn < i2cbe_pkg::ACK_SLOT_BIT
                    && ph == 2'd2)
                begin
                    shift_next = {sb[6:0], 1'b0};
                end
                if (ph != ph_count - 2'd1)
                begin
                    phase_next = ph + 2'd1;
                end
                else if (bitn < last_bit)
                begin
                    phase_next = 2'd0;
                    bit_next   = bitn + 4'd1;
                end
                else
                begin
                    if (cmd == i2cbe_pkg::OP_READ_ACK)
                    begin
                        sda_next = 1'b1;
                    end
                    cmd_next   = i2cbe_pkg::OP_NONE;
                    phase_next = 2'd0;
                    bit_next   = 4'd0;
                    done_next  = 1'b1;
                end
            end
            else
            begin
                tick_next = tc + 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= i2cbe_pkg::OP_NONE;
            phase_reg     <= 2'd0;
            bit_reg       <= 4'd0;
            tick_reg      <= 10'd0;
            shift_reg     <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            rx_reg        <= 8'd0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_ticks_reg <= i2cbe_pkg::RESET_PHASE_TICKS;
        end
        else
        begin
            if (cfg_valid)
            begin
                phase_ticks_reg <= cfg_data;
            end
            if (advance)
            begin
                cmd_reg   <= cmd_next;
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                tick_reg  <= tick_next;
                shift_reg <= shift_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                ack_reg   <= ack_next;
                rx_reg    <= rx_next;
                done_reg  <= done_next;
            end
            // hold the beat until taken; refill on the same edge when possible
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_out     = scl_reg;
    assign sda_release = sda_reg;
    assign busy_res    = (cmd_reg != i2cbe_pkg::OP_NONE);
    assign done_res    = done_reg;
    assign nack_seen   = ack_reg;
    assign rx_byte     = rx_reg;

endmodule
